### design/assert_macros.svh
// Assertion macros for the checker of the sender window.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### design/srsw_pkg.sv
// Shared constants and types of the selective-repeat sender window.
package srsw_pkg;

   localparam int SEQ_COUNT = 8;
   localparam int SEQ_W     = $clog2(SEQ_COUNT);
   localparam int PAYLOAD_W = 32;
   localparam int KIND_W    = 2;
   localparam int WIN_W     = 3;
   localparam int CNT_W     = $clog2(SEQ_COUNT + 1);

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

   // item kinds
   localparam logic [KIND_W-1:0] KIND_SEND    = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_ACK     = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_TIMEOUT = KIND_W'(2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SLIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic slide_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic need_slide;
      logic slide_go;
   } status_type;

endpackage

### design/srsw_ctrl.sv
// Sequencing state machine of the sender window.
module srsw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  srsw_pkg::status_type status,
   output srsw_pkg::cmd_type    cmd
);

   srsw_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srsw_pkg::ST_IDLE: begin
            if (req_valid) state_in = srsw_pkg::ST_EXEC;
         end
         srsw_pkg::ST_EXEC: begin
            state_in = status.need_slide ? srsw_pkg::ST_SLIDE : srsw_pkg::ST_DONE;
         end
         srsw_pkg::ST_SLIDE: begin
            if (!status.slide_go) state_in = srsw_pkg::ST_DONE;
         end
         srsw_pkg::ST_DONE: begin
            if (out_free) state_in = srsw_pkg::ST_IDLE;
         end
         default: state_in = srsw_pkg::ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         srsw_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         srsw_pkg::ST_EXEC:  cmd.exec       = 1'b1;
         srsw_pkg::ST_SLIDE: cmd.slide_step = status.slide_go;
         srsw_pkg::ST_DONE:  cmd.load_out   = out_free;
         default: cmd = '0;
      endcase
   end

   // hold the result valid until taken
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srsw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/srsw_datapath.sv
// Window state, packet store and result registers of the sender window.
module srsw_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  srsw_pkg::cmd_type              cmd,
   output srsw_pkg::status_type           status,
   input  logic                           csr_wr_en,
   input  logic [srsw_pkg::WIN_W-1:0]     csr_wr_data,
   input  logic [srsw_pkg::KIND_W-1:0]    req_kind,
   input  logic [srsw_pkg::PAYLOAD_W-1:0] req_payload,
   input  logic [srsw_pkg::SEQ_W-1:0]     req_ack_seq,
   input  logic                           req_ack_intact,
   input  logic [srsw_pkg::SEQ_W-1:0]     req_timeout_seq,
   output logic                           rsp_accepted,
   output logic                           rsp_tx_valid,
   output logic [srsw_pkg::SEQ_W-1:0]     rsp_tx_seq,
   output logic [srsw_pkg::PAYLOAD_W-1:0] rsp_tx_payload,
   output logic                           rsp_start_timer,
   output logic                           rsp_stop_timer,
   output logic [srsw_pkg::SEQ_W-1:0]     rsp_timer_seq,
   output logic [srsw_pkg::SEQ_W-1:0]     rsp_base_now,
   output logic [srsw_pkg::SEQ_W-1:0]     rsp_next_now,
   output logic                           rsp_window_full
);

   localparam int SW = srsw_pkg::SEQ_W;
   localparam int PW = srsw_pkg::PAYLOAD_W;

   // window control state
   logic [srsw_pkg::WIN_W-1:0]  window_ff;
   logic [SW-1:0]               base_ff;
   logic [SW-1:0]               next_ff;
   logic [srsw_pkg::SEQ_COUNT-1:0] acked_ff;
   logic [srsw_pkg::CNT_W-1:0]  cnt_ff;

   // captured item
   logic [srsw_pkg::KIND_W-1:0] cap_kind_ff;
   logic [PW-1:0]               cap_payload_ff;
   logic [SW-1:0]               cap_ack_ff;
   logic                        cap_intact_ff;
   logic [SW-1:0]               cap_timeout_ff;

   // packet store and its read register
   logic [PW-1:0]               mem [srsw_pkg::SEQ_COUNT];
   logic [PW-1:0]               rd_ff;

   // partial result built during execution
   logic                        res_accepted_ff, res_accepted_in;
   logic                        res_tx_valid_ff, res_tx_valid_in;
   logic                        res_from_mem_ff, res_from_mem_in;
   logic [SW-1:0]               res_tx_seq_ff, res_tx_seq_in;
   logic                        res_start_ff, res_start_in;
   logic                        res_stop_ff, res_stop_in;
   logic [SW-1:0]               res_timer_seq_ff, res_timer_seq_in;

   // output registers
   logic                        out_accepted_ff;
   logic                        out_tx_valid_ff;
   logic [SW-1:0]               out_tx_seq_ff;
   logic [PW-1:0]               out_tx_payload_ff;
   logic                        out_start_ff;
   logic                        out_stop_ff;
   logic [SW-1:0]               out_timer_seq_ff;
   logic [SW-1:0]               out_base_ff;
   logic [SW-1:0]               out_next_ff;
   logic                        out_full_ff;

   logic [srsw_pkg::WIN_W-1:0]  eff_win;
   logic                        full;
   logic [SW-1:0]               ack_off;
   logic                        ack_in_win;
   logic                        ack_in_range;
   logic                        to_in_range;
   logic                        do_send;

   // clamp the window to between one and SEQ_COUNT-1
   always_comb begin
      priority if (window_ff == '0) begin
         eff_win = srsw_pkg::WIN_W'(1);
      end else if (srsw_pkg::WIN_W'(srsw_pkg::SEQ_COUNT - 1) < window_ff) begin
         eff_win = srsw_pkg::WIN_W'(srsw_pkg::SEQ_COUNT - 1);
      end else begin
         eff_win = window_ff;
      end
   end

   // full and in-window tests, wrapping modulo the sequence count
   assign full         = (SW'(base_ff + SW'(eff_win))) == next_ff;
   assign ack_off      = SW'(cap_ack_ff - base_ff);
   assign ack_in_win   = {1'b0, ack_off} < (SW + 1)'(eff_win);
   assign ack_in_range = {1'b0, cap_ack_ff} < (SW + 1)'(srsw_pkg::SEQ_COUNT);
   assign to_in_range  = {1'b0, cap_timeout_ff} < (SW + 1)'(srsw_pkg::SEQ_COUNT);
   assign do_send      = cmd.exec && (cap_kind_ff == srsw_pkg::KIND_SEND) && !full;

   assign status.need_slide = (cap_kind_ff == srsw_pkg::KIND_ACK) && cap_intact_ff &&
                              ack_in_range && ack_in_win;
   assign status.slide_go   = acked_ff[base_ff] &&
                              (cnt_ff != srsw_pkg::CNT_W'(srsw_pkg::SEQ_COUNT));

   // decode the captured item into its result fields
   always_comb begin
      res_accepted_in  = 1'b0;
      res_tx_valid_in  = 1'b0;
      res_from_mem_in  = 1'b0;
      res_tx_seq_in    = '0;
      res_start_in     = 1'b0;
      res_stop_in      = 1'b0;
      res_timer_seq_in = '0;
      unique case (cap_kind_ff)
         srsw_pkg::KIND_SEND: begin
            if (!full) begin
               res_accepted_in  = 1'b1;
               res_tx_valid_in  = 1'b1;
               res_tx_seq_in    = next_ff;
               res_start_in     = 1'b1;
               res_timer_seq_in = next_ff;
            end
         end
         srsw_pkg::KIND_ACK: begin
            if (cap_intact_ff) begin
               res_stop_in      = 1'b1;
               res_timer_seq_in = cap_ack_ff;
            end
         end
         srsw_pkg::KIND_TIMEOUT: begin
            if (to_in_range) begin
               res_tx_valid_in  = 1'b1;
               res_from_mem_in  = 1'b1;
               res_tx_seq_in    = cap_timeout_ff;
               res_start_in     = 1'b1;
               res_timer_seq_in = cap_timeout_ff;
            end
         end
         default: begin
            res_accepted_in = 1'b0;
         end
      endcase
   end

   // window control state: config, send advance, ack mark, slide
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= srsw_pkg::WINDOW_RESET;
         base_ff   <= '0;
         next_ff   <= '0;
         acked_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         if (csr_wr_en) window_ff <= csr_wr_data;
         if (cmd.exec) begin
            cnt_ff <= '0;
            if (status.need_slide) acked_ff[cap_ack_ff] <= 1'b1;
         end
         if (do_send) next_ff <= SW'(next_ff + SW'(1));
         if (cmd.slide_step) begin
            acked_ff[base_ff] <= 1'b0;
            base_ff           <= SW'(base_ff + SW'(1));
            cnt_ff            <= srsw_pkg::CNT_W'(cnt_ff + srsw_pkg::CNT_W'(1));
         end
      end
   end

   // capture the item at acceptance
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_kind_ff    <= req_kind;
         cap_payload_ff <= req_payload;
         cap_ack_ff     <= req_ack_seq;
         cap_intact_ff  <= req_ack_intact;
         cap_timeout_ff <= req_timeout_seq;
      end
   end

   // packet store: write on send, registered read at the timeout number
   always_ff @(posedge clock) begin
      if (do_send) mem[next_ff] <= cap_payload_ff;
      rd_ff <= mem[cap_timeout_ff];
   end

   // hold the decoded result until the output load
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_accepted_ff  <= res_accepted_in;
         res_tx_valid_ff  <= res_tx_valid_in;
         res_from_mem_ff  <= res_from_mem_in;
         res_tx_seq_ff    <= res_tx_seq_in;
         res_start_ff     <= res_start_in;
         res_stop_ff      <= res_stop_in;
         res_timer_seq_ff <= res_timer_seq_in;
      end
   end

   // load the output register with fields and the status after the item
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_accepted_ff  <= res_accepted_ff;
         out_tx_valid_ff  <= res_tx_valid_ff;
         out_tx_seq_ff    <= res_tx_seq_ff;
         if (!res_tx_valid_ff) begin
            out_tx_payload_ff <= '0;
         end else if (res_from_mem_ff) begin
            out_tx_payload_ff <= rd_ff;
         end else begin
            out_tx_payload_ff <= cap_payload_ff;
         end
         out_start_ff     <= res_start_ff;
         out_stop_ff      <= res_stop_ff;
         out_timer_seq_ff <= res_timer_seq_ff;
         out_base_ff      <= base_ff;
         out_next_ff      <= next_ff;
         out_full_ff      <= full;
      end
   end

   assign rsp_accepted    = out_accepted_ff;
   assign rsp_tx_valid    = out_tx_valid_ff;
   assign rsp_tx_seq      = out_tx_seq_ff;
   assign rsp_tx_payload  = out_tx_payload_ff;
   assign rsp_start_timer = out_start_ff;
   assign rsp_stop_timer  = out_stop_ff;
   assign rsp_timer_seq   = out_timer_seq_ff;
   assign rsp_base_now    = out_base_ff;
   assign rsp_next_now    = out_next_ff;
   assign rsp_window_full = out_full_ff;

endmodule

### design/selective_repeat_sender_window_core.sv
// Top level of the selective-repeat sender window.
// Input channel req_*: one item per handshake, kind 0 send, 1 ack, 2 timeout.
// Result channel rsp_*: exactly one result item per input item, in order.
// csr_wr_en/csr_wr_data write the window size (reset value 4); the user must
// write it only while idle, as the block does not enforce this. An item is
// taken in idle and executed in the next cycle. An ack that marks its slot
// then passes through the slide loop of the controller, where the base
// slides over the acknowledged slots, one slot per cycle. The result is then
// loaded into the output register in the done state once that register is
// free.
// The packet store is read through a registered port, so a timeout
// retransmission needs no extra state in the controller.
// Reset (synchronous, active high) clears base, next number, ack marks and
// the result valid; the packet store is not cleared.
// When the receiver stalls, the result is held in the output register. One
// more item may still be taken and executed; it then waits for the output
// register, and req_ready stays low until the pending result is taken.
module selective_repeat_sender_window_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [srsw_pkg::KIND_W-1:0]    req_kind,
   input  logic [srsw_pkg::PAYLOAD_W-1:0] req_payload,
   input  logic [srsw_pkg::SEQ_W-1:0]     req_ack_seq,
   input  logic                           req_ack_intact,
   input  logic [srsw_pkg::SEQ_W-1:0]     req_timeout_seq,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic                           rsp_tx_valid,
   output logic [srsw_pkg::SEQ_W-1:0]     rsp_tx_seq,
   output logic [srsw_pkg::PAYLOAD_W-1:0] rsp_tx_payload,
   output logic                           rsp_start_timer,
   output logic                           rsp_stop_timer,
   output logic [srsw_pkg::SEQ_W-1:0]     rsp_timer_seq,
   output logic [srsw_pkg::SEQ_W-1:0]     rsp_base_now,
   output logic [srsw_pkg::SEQ_W-1:0]     rsp_next_now,
   output logic                           rsp_window_full,
   input  logic                           csr_wr_en,
   input  logic [srsw_pkg::WIN_W-1:0]     csr_wr_data
);

   srsw_pkg::cmd_type    cmd;
   srsw_pkg::status_type status;

   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   srsw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_kind        (req_kind),
      .req_payload     (req_payload),
      .req_ack_seq     (req_ack_seq),
      .req_ack_intact  (req_ack_intact),
      .req_timeout_seq (req_timeout_seq),
      .rsp_accepted    (rsp_accepted),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_seq      (rsp_tx_seq),
      .rsp_tx_payload  (rsp_tx_payload),
      .rsp_start_timer (rsp_start_timer),
      .rsp_stop_timer  (rsp_stop_timer),
      .rsp_timer_seq   (rsp_timer_seq),
      .rsp_base_now    (rsp_base_now),
      .rsp_next_now    (rsp_next_now),
      .rsp_window_full (rsp_window_full)
   );

endmodule

### design/srsw_checker.sv
// Port-level checks of the sender window, bound to the top level.
`include "assert_macros.svh"

module srsw_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_accepted,
   input logic rsp_tx_valid,
   input logic rsp_start_timer,
   input logic rsp_stop_timer
);

   // one item at a time: no new item right after one is taken
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled result stays valid
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // every transmission starts or restarts its timer
   `ASSERT_IMPLY(a_tx_starts_timer, clock, reset, rsp_valid && rsp_tx_valid,
      rsp_start_timer && !rsp_stop_timer)

   // a taken send always transmits
   `ASSERT_IMPLY(a_accept_tx, clock, reset, rsp_valid && rsp_accepted, rsp_tx_valid)

endmodule

bind selective_repeat_sender_window_core srsw_checker u_srsw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_accepted    (rsp_accepted),
   .rsp_tx_valid    (rsp_tx_valid),
   .rsp_start_timer (rsp_start_timer),
   .rsp_stop_timer  (rsp_stop_timer)
);
